FILE: design/segsd_pkg.sv
package segsd_pkg;

    // Width of the parallel threshold register and its value after reset.
    localparam int THR_WIDTH = 32;

    typedef logic [THR_WIDTH-1:0] thr_t;

    localparam thr_t THR_RESET = thr_t'(1);

endpackage

FILE: design/segment_segment_distance_sq.sv
// Throughput: one segment pair per cycle while the output is not stalled.
// Every stage carries its own valid bit, and a stage moves whenever the stage after it can take data.
// Reset: rst_n is asynchronous and active low. It clears all valid bits and sets
// the parallel threshold register to 1. Data registers are not reset.
module segment_segment_distance_sq #(
    parameter int COORD_WIDTH = 16,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  segsd_pkg::thr_t               parallel_threshold,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] s1_start_x,
    input  logic signed [COORD_WIDTH-1:0] s1_start_y,
    input  logic signed [COORD_WIDTH-1:0] s1_start_z,
    input  logic signed [COORD_WIDTH-1:0] s1_end_x,
    input  logic signed [COORD_WIDTH-1:0] s1_end_y,
    input  logic signed [COORD_WIDTH-1:0] s1_end_z,
    input  logic signed [COORD_WIDTH-1:0] s2_start_x,
    input  logic signed [COORD_WIDTH-1:0] s2_start_y,
    input  logic signed [COORD_WIDTH-1:0] s2_start_z,
    input  logic signed [COORD_WIDTH-1:0] s2_end_x,
    input  logic signed [COORD_WIDTH-1:0] s2_end_y,
    input  logic signed [COORD_WIDTH-1:0] s2_end_z,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [2*COORD_WIDTH+1:0]      squared_distance
);
    import segsd_pkg::*;

    // Width plan. Coordinate differences take one extra bit. A dot product of three
    // terms takes two more bits than one term. Each numerator is a difference of
    // two products of dot products.
    localparam int DW    = COORD_WIDTH + 1;
    localparam int PW    = 2 * DW;
    localparam int AW    = PW + 2;
    localparam int MW    = 2 * AW;
    localparam int NW    = MW + 2;
    localparam int RW    = NW + 1;
    localparam int QW    = FRAC_BITS + 1;
    localparam int DPW   = DW + FRAC_BITS + 3;
    localparam int SQW   = 2 * DPW;
    localparam int ACW   = SQW + 2;
    localparam int OUTW  = 2 * COORD_WIDTH + 2;
    localparam int VW    = 9 * DW;

    // Stage numbering. The divider takes one stage for each quotient bit.
    localparam int S_DIFF = 0;
    localparam int S_PROD = 1;
    localparam int S_DOT  = 2;
    localparam int S_MUL  = 3;
    localparam int S_SNUM = 4;
    localparam int S_TCL  = 5;
    localparam int S_DIV0 = 6;
    localparam int S_SCP  = S_DIV0 + QW;
    localparam int S_DP   = S_SCP + 1;
    localparam int S_SQ   = S_DP + 1;
    localparam int S_OUT  = S_SQ + 1;
    localparam int NST    = S_OUT + 1;

    localparam logic [OUTW-1:0] MAX_DIST =
        OUTW'(3) * ((OUTW'(1) << COORD_WIDTH) - OUTW'(1)) *
        ((OUTW'(1) << COORD_WIDTH) - OUTW'(1));

    // Configuration register. The port always takes a write request.
    thr_t thr_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else if (cfg_valid)
        begin
            thr_reg <= parallel_threshold;
        end
    end

    // Flow control. A stage loads when it is empty or when its contents move on.
    // Bubbles therefore close up, and a finished result can wait in the last stage
    // while new requests still enter.
    logic [NST-1:0] v_reg;
    logic [NST-1:0] en;
    logic [NST-1:0] v_shift;

    always_comb
    begin
        en[NST-1] = !v_reg[NST-1] || out_ready;
        for (int k = NST - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    // Valid bit that each stage takes when it loads.
    assign v_shift = {v_reg[NST-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NST; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_shift[k];
                end
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NST-1];

    // Stage DIFF: u = P1e - P1s, v = P2e - P2s, w = P1s - P2s.
    // These are packed per axis: u at slots 0..2, v at 3..5, w at 6..8.
    logic [VW-1:0] vec_diff_reg;
    logic [VW-1:0] vec_diff_next;

    always_comb
    begin
        vec_diff_next = '0;
        vec_diff_next[0*DW +: DW] = DW'(s1_end_x) - DW'(s1_start_x);
        vec_diff_next[1*DW +: DW] = DW'(s1_end_y) - DW'(s1_start_y);
        vec_diff_next[2*DW +: DW] = DW'(s1_end_z) - DW'(s1_start_z);
        vec_diff_next[3*DW +: DW] = DW'(s2_end_x) - DW'(s2_start_x);
        vec_diff_next[4*DW +: DW] = DW'(s2_end_y) - DW'(s2_start_y);
        vec_diff_next[5*DW +: DW] = DW'(s2_end_z) - DW'(s2_start_z);
        vec_diff_next[6*DW +: DW] = DW'(s1_start_x) - DW'(s2_start_x);
        vec_diff_next[7*DW +: DW] = DW'(s1_start_y) - DW'(s2_start_y);
        vec_diff_next[8*DW +: DW] = DW'(s1_start_z) - DW'(s2_start_z);
    end

    always_ff @(posedge clk)
    begin
        if (en[S_DIFF])
        begin
            vec_diff_reg <= vec_diff_next;
        end
    end

    // Stage PROD: the fifteen per-axis products. Slot 5*i+0..4 holds
    // uu, uv, vv, uw and vw for axis i.
    logic [15*PW-1:0] prod_reg;
    logic [15*PW-1:0] prod_next;
    logic [VW-1:0]    vec_prod_reg;

    always_comb
    begin
        logic signed [DW-1:0] ui;
        logic signed [DW-1:0] vi;
        logic signed [DW-1:0] wi;
        prod_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            ui = $signed(vec_diff_reg[i*DW +: DW]);
            vi = $signed(vec_diff_reg[(3+i)*DW +: DW]);
            wi = $signed(vec_diff_reg[(6+i)*DW +: DW]);
            prod_next[(5*i+0)*PW +: PW] = PW'(ui) * PW'(ui);
            prod_next[(5*i+1)*PW +: PW] = PW'(ui) * PW'(vi);
            prod_next[(5*i+2)*PW +: PW] = PW'(vi) * PW'(vi);
            prod_next[(5*i+3)*PW +: PW] = PW'(ui) * PW'(wi);
            prod_next[(5*i+4)*PW +: PW] = PW'(vi) * PW'(wi);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[S_PROD])
        begin
            prod_reg     <= prod_next;
            vec_prod_reg <= vec_diff_reg;
        end
    end

    // Stage DOT: a = u.u, b = u.v, c = v.v, d = u.w, e = v.w.
    logic signed [AW-1:0] dot_a_reg;
    logic signed [AW-1:0] dot_b_reg;
    logic signed [AW-1:0] dot_c_reg;
    logic signed [AW-1:0] dot_d_reg;
    logic signed [AW-1:0] dot_e_reg;
    logic [VW-1:0]        vec_dot_reg;
    logic signed [AW-1:0] dot_next [5];

    always_comb
    begin
        for (int j = 0; j < 5; j++)
        begin
            dot_next[j] = AW'($signed(prod_reg[j*PW +: PW]))
                        + AW'($signed(prod_reg[(5+j)*PW +: PW]))
                        + AW'($signed(prod_reg[(10+j)*PW +: PW]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[S_DOT])
        begin
            dot_a_reg   <= dot_next[0];
            dot_b_reg   <= dot_next[1];
            dot_c_reg   <= dot_next[2];
            dot_d_reg   <= dot_next[3];
            dot_e_reg   <= dot_next[4];
            vec_dot_reg <= vec_prod_reg;
        end
    end

    // Stage MUL: the six products that form the determinant and both numerators.
    logic signed [MW-1:0] m_ac_reg;
    logic signed [MW-1:0] m_bb_reg;
    logic signed [MW-1:0] m_be_reg;
    logic signed [MW-1:0] m_cd_reg;
    logic signed [MW-1:0] m_ae_reg;
    logic signed [MW-1:0] m_bd_reg;
    logic signed [AW-1:0] mul_a_reg;
    logic signed [AW-1:0] mul_b_reg;
    logic signed [AW-1:0] mul_c_reg;
    logic signed [AW-1:0] mul_d_reg;
    logic signed [AW-1:0] mul_e_reg;
    logic [VW-1:0]        vec_mul_reg;

    always_ff @(posedge clk)
    begin
        if (en[S_MUL])
        begin
            m_ac_reg    <= MW'(dot_a_reg) * MW'(dot_c_reg);
            m_bb_reg    <= MW'(dot_b_reg) * MW'(dot_b_reg);
            m_be_reg    <= MW'(dot_b_reg) * MW'(dot_e_reg);
            m_cd_reg    <= MW'(dot_c_reg) * MW'(dot_d_reg);
            m_ae_reg    <= MW'(dot_a_reg) * MW'(dot_e_reg);
            m_bd_reg    <= MW'(dot_b_reg) * MW'(dot_d_reg);
            mul_a_reg   <= dot_a_reg;
            mul_b_reg   <= dot_b_reg;
            mul_c_reg   <= dot_c_reg;
            mul_d_reg   <= dot_d_reg;
            mul_e_reg   <= dot_e_reg;
            vec_mul_reg <= vec_dot_reg;
        end
    end

    // Stage SNUM: form the determinant and take the parallel decision. Then clamp
    // the parameter of segment 1 to its ends.
    logic signed [NW-1:0] sn_reg;
    logic signed [NW-1:0] sd_reg;
    logic signed [NW-1:0] tn_reg;
    logic signed [NW-1:0] td_reg;
    logic signed [AW-1:0] sn_a_reg;
    logic signed [AW-1:0] sn_b_reg;
    logic signed [AW-1:0] sn_d_reg;
    logic [VW-1:0]        vec_sn_reg;
    logic signed [NW-1:0] sn_next;
    logic signed [NW-1:0] sd_next;
    logic signed [NW-1:0] tn_next;
    logic signed [NW-1:0] td_next;

    always_comb
    begin
        logic signed [NW-1:0] det;
        logic                 par;
        det = NW'(m_ac_reg) - NW'(m_bb_reg);
        par = !det[NW-1] && (det < $signed({1'b0, (NW-1)'(thr_reg)}));
        sd_next = det;
        td_next = det;
        if (par)
        begin
            sn_next = '0;
            sd_next = NW'(1);
            tn_next = NW'(mul_e_reg);
            td_next = NW'(mul_c_reg);
        end
        else
        begin
            sn_next = NW'(m_be_reg) - NW'(m_cd_reg);
            tn_next = NW'(m_ae_reg) - NW'(m_bd_reg);
            if (sn_next < 0)
            begin
                sn_next = '0;
                tn_next = NW'(mul_e_reg);
                td_next = NW'(mul_c_reg);
            end
            else if (sn_next > det)
            begin
                sn_next = det;
                tn_next = NW'(mul_e_reg) + NW'(mul_b_reg);
                td_next = NW'(mul_c_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[S_SNUM])
        begin
            sn_reg     <= sn_next;
            sd_reg     <= sd_next;
            tn_reg     <= tn_next;
            td_reg     <= td_next;
            sn_a_reg   <= mul_a_reg;
            sn_b_reg   <= mul_b_reg;
            sn_d_reg   <= mul_d_reg;
            vec_sn_reg <= vec_mul_reg;
        end
    end

    // Stage TCL: clamp the parameter of segment 2. Where it had to be clamped,
    // recompute segment 1 against the chosen end of segment 2. The stage also
    // flags divisions whose quotient is forced to zero.
    logic [RW-1:0] tcl_sn_reg;
    logic [RW-1:0] tcl_sd_reg;
    logic [RW-1:0] tcl_tn_reg;
    logic [RW-1:0] tcl_td_reg;
    logic          tcl_sz_reg;
    logic          tcl_tz_reg;
    logic [VW-1:0] vec_tcl_reg;

    logic signed [NW-1:0] cs_n;
    logic signed [NW-1:0] cs_d;
    logic signed [NW-1:0] ct_n;

    always_comb
    begin
        logic signed [AW:0] edge_v;
        logic               redo;
        cs_n   = sn_reg;
        cs_d   = sd_reg;
        ct_n   = tn_reg;
        edge_v = '0;
        redo   = 1'b0;
        if (tn_reg < 0)
        begin
            ct_n   = '0;
            edge_v = -(AW + 1)'(sn_d_reg);
            redo   = 1'b1;
        end
        else if (tn_reg > td_reg)
        begin
            ct_n   = td_reg;
            edge_v = (AW + 1)'(sn_b_reg) - (AW + 1)'(sn_d_reg);
            redo   = 1'b1;
        end
        if (redo)
        begin
            if (edge_v < 0)
            begin
                cs_n = '0;
            end
            else if (edge_v > (AW + 1)'(sn_a_reg))
            begin
                cs_n = sd_reg;
            end
            else
            begin
                cs_n = NW'(edge_v);
                cs_d = NW'(sn_a_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[S_TCL])
        begin
            tcl_sn_reg  <= RW'($unsigned(cs_n));
            tcl_sd_reg  <= RW'($unsigned(cs_d));
            tcl_tn_reg  <= RW'($unsigned(ct_n));
            tcl_td_reg  <= RW'($unsigned(td_reg));
            tcl_sz_reg  <= (cs_n <= 0) || (cs_d <= 0);
            tcl_tz_reg  <= (ct_n <= 0) || (td_reg <= 0);
            vec_tcl_reg <= vec_sn_reg;
        end
    end

    // Two restoring dividers run side by side, one quotient bit per stage. The
    // first stage produces the integer bit. Each later stage shifts the remainder
    // and produces one fraction bit.
    logic [RW-1:0] dv_sr_reg [QW];
    logic [RW-1:0] dv_sd_reg [QW];
    logic [QW-1:0] dv_sq_reg [QW];
    logic [RW-1:0] dv_tr_reg [QW];
    logic [RW-1:0] dv_td_reg [QW];
    logic [QW-1:0] dv_tq_reg [QW];
    logic          dv_sz_reg [QW];
    logic          dv_tz_reg [QW];
    logic [VW-1:0] dv_vec_reg [QW];

    for (genvar j = 0; j < QW; j++)
    begin : g_div
        logic [RW-1:0] s_rem;
        logic [RW-1:0] s_den;
        logic [RW-1:0] t_rem;
        logic [RW-1:0] t_den;
        logic [QW-1:0] s_q;
        logic [QW-1:0] t_q;
        logic          s_ge;
        logic          t_ge;
        logic          s_z_in;
        logic          t_z_in;
        logic [VW-1:0] vec_in;

        if (j == 0)
        begin : g_first
            assign s_rem  = tcl_sn_reg;
            assign s_den  = tcl_sd_reg;
            assign t_rem  = tcl_tn_reg;
            assign t_den  = tcl_td_reg;
            assign s_q    = '0;
            assign t_q    = '0;
            assign s_z_in = tcl_sz_reg;
            assign t_z_in = tcl_tz_reg;
            assign vec_in = vec_tcl_reg;
        end
        else
        begin : g_next
            assign s_rem  = dv_sr_reg[j-1] << 1;
            assign s_den  = dv_sd_reg[j-1];
            assign t_rem  = dv_tr_reg[j-1] << 1;
            assign t_den  = dv_td_reg[j-1];
            assign s_q    = dv_sq_reg[j-1] << 1;
            assign t_q    = dv_tq_reg[j-1] << 1;
            assign s_z_in = dv_sz_reg[j-1];
            assign t_z_in = dv_tz_reg[j-1];
            assign vec_in = dv_vec_reg[j-1];
        end

        assign s_ge = s_rem >= s_den;
        assign t_ge = t_rem >= t_den;

        always_ff @(posedge clk)
        begin
            if (en[S_DIV0 + j])
            begin
                dv_sr_reg[j]  <= s_ge ? (s_rem - s_den) : s_rem;
                dv_tr_reg[j]  <= t_ge ? (t_rem - t_den) : t_rem;
                dv_sd_reg[j]  <= s_den;
                dv_td_reg[j]  <= t_den;
                dv_sq_reg[j]  <= s_q | QW'(s_ge);
                dv_tq_reg[j]  <= t_q | QW'(t_ge);
                dv_sz_reg[j]  <= s_z_in;
                dv_tz_reg[j]  <= t_z_in;
                dv_vec_reg[j] <= vec_in;
            end
        end
    end

    // Stage SCP: sc*u and tc*v per axis. A forced-zero division gives 0.
    logic signed [DPW-1:0] scu_reg [3];
    logic signed [DPW-1:0] tcv_reg [3];
    logic [VW-1:0]         vec_scp_reg;

    always_ff @(posedge clk)
    begin
        logic [QW-1:0] sc;
        logic [QW-1:0] tc;
        sc = dv_sz_reg[QW-1] ? '0 : dv_sq_reg[QW-1];
        tc = dv_tz_reg[QW-1] ? '0 : dv_tq_reg[QW-1];
        if (en[S_SCP])
        begin
            for (int i = 0; i < 3; i++)
            begin
                scu_reg[i] <= $signed(DPW'(sc)) *
                              DPW'($signed(dv_vec_reg[QW-1][i*DW +: DW]));
                tcv_reg[i] <= $signed(DPW'(tc)) *
                              DPW'($signed(dv_vec_reg[QW-1][(3+i)*DW +: DW]));
            end
            vec_scp_reg <= dv_vec_reg[QW-1];
        end
    end

    // Stage DP: the difference vector, with FRAC_BITS fraction bits.
    logic signed [DPW-1:0] dp_reg [3];

    always_ff @(posedge clk)
    begin
        if (en[S_DP])
        begin
            for (int i = 0; i < 3; i++)
            begin
                dp_reg[i] <= (DPW'($signed(vec_scp_reg[(6+i)*DW +: DW])) <<< FRAC_BITS)
                           + scu_reg[i] - tcv_reg[i];
            end
        end
    end

    // Stage SQ: square each component.
    logic [SQW-1:0] sq_reg [3];

    always_ff @(posedge clk)
    begin
        if (en[S_SQ])
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= $unsigned(SQW'(dp_reg[i]) * SQW'(dp_reg[i]));
            end
        end
    end

    // Stage OUT: sum the squares and round half up to whole units.
    logic [OUTW-1:0] res_reg;
    logic [ACW-1:0]  acc;

    assign acc = ACW'(sq_reg[0]) + ACW'(sq_reg[1]) + ACW'(sq_reg[2])
               + (ACW'(1) << (2 * FRAC_BITS - 1));

    always_ff @(posedge clk)
    begin
        if (en[S_OUT])
        begin
            res_reg <= acc[2*FRAC_BITS +: OUTW];
        end
    end

    assign squared_distance = res_reg;

    // A stalled input must mean that the first stage is full.
    assert property (@(posedge clk) disable iff (!rst_n) !in_ready |-> v_reg[S_DIFF])
        else $error("input stalled with empty first stage");

    // After the clamps, every division that is not forced to zero has num <= den.
    assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[S_TCL] && !tcl_sz_reg |-> tcl_sn_reg <= tcl_sd_reg)
        else $error("segment 1 parameter exceeds one");

    assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[S_TCL] && !tcl_tz_reg |-> tcl_tn_reg <= tcl_td_reg)
        else $error("segment 2 parameter exceeds one");

    // Parameters stay in [0,1], so the distance stays within the bounding box.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> squared_distance <= MAX_DIST)
        else $error("distance out of range");

endmodule
